[hw/rtl/mhlp_pkg.sv]
// Package: shared types, codes and constants of the hash table block.
`timescale 1ns / 1ps
`default_nettype none
package mhlp_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 128;
  localparam int KEY_BITS    = 20;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SLOT_W      = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 8;
  localparam int MULT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT  = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);
  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(40503);

  // Hash arithmetic: 16 fractional bits, cut to hundredths, scaled by size
  localparam int FRAC_W      = 16;
  localparam int HUNDRED     = 100;
  localparam int PCT_W       = 7;
  localparam int PCT_MUL_W   = FRAC_W + PCT_W;
  localparam int SCL_W       = PCT_W + SIZE_W;
  // x / 100 == (x * 5243) >> 19, exact for x below 2^15
  localparam int RECIP       = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int HOME_MUL_W  = SCL_W + RECIP_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_ZERO = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_BITS-1:0] key_in;
    logic [SLOT_W-1:0]   slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [KEY_BITS-1:0] key_out;
    status_t             status;
  } out_item_t;

  // Source of the result fields
  typedef enum logic [1:0] {
    RES_SLOT_HELD,
    RES_SLOT_KEY,
    RES_ZERO
  } res_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH_MUL,
    ST_HASH_PCT,
    ST_HASH_SCALE,
    ST_HASH_HOME,
    ST_PROBE,
    ST_READ_ISSUE,
    ST_READ_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     hash_mul;
    logic     hash_pct;
    logic     hash_scale;
    logic     hash_home;
    logic     probe_issue;
    logic     read_issue;
    logic     wr_en;
    logic     emit;
    res_sel_t res_sel;
    status_t  res_status;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic in_read;
    logic in_zero_key;
    logic iss_more;
    logic hit_empty;
    logic hit_dup;
    logic hit_full;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/mhlp_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mhlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hw/rtl/mhlp_datapath.sv]
// Datapath: config registers, hash pipeline, probe address, slot store and result registers.
`timescale 1ns / 1ps
`default_nettype none
module mhlp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mhlp_pkg::in_item_t            in_payload,
  input  wire logic                          cfg_we,
  input  wire logic [mhlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mhlp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire mhlp_pkg::ctl_t                ctl,
  output mhlp_pkg::sts_t                     sts,
  output logic                               out_strobe,
  output mhlp_pkg::out_item_t                out_payload
);
  import mhlp_pkg::*;

  logic [SIZE_W-1:0]     table_size_r;
  logic [MULT_W-1:0]     hash_mult_r;
  logic [CNT_W-1:0]      size_use;

  logic [KEY_BITS-1:0]   key_r;
  logic [SLOT_W-1:0]     slot_r;

  logic [2*FRAC_W-1:0]   mul_full;
  logic [FRAC_W-1:0]     mul_r;
  logic [PCT_MUL_W-1:0]  pct_full;
  logic [PCT_W-1:0]      pct_r;
  logic [SCL_W-1:0]      scl_full;
  logic [SCL_W-1:0]      scl_r;
  logic [HOME_MUL_W-1:0] home_full;

  logic [ADDR_W-1:0]     iss_pos_r;
  logic [CNT_W-1:0]      iss_cnt_r;
  logic [CNT_W-1:0]      pos_inc;

  logic [ADDR_W-1:0]     raddr;
  logic                  issue;
  logic                  rd_vld_r;
  logic [ADDR_W-1:0]     rd_pos_r;
  logic                  rd_last_r;
  logic                  rd_bit_r;
  logic [KEY_BITS-1:0]   rdata;
  logic [KEY_BITS-1:0]   held;

  logic [TABLE_DEPTH-1:0] valid_r;

  logic                  out_strobe_r;
  out_item_t             out_payload_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
      hash_mult_r  <= MULT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TABLE_SIZE) begin
        table_size_r <= cfg_data[SIZE_W-1:0];
      end else if (cfg_index == CFG_HASH_MULT) begin
        hash_mult_r <= cfg_data[MULT_W-1:0];
      end
    end
  end

  // Clamp size into 1..depth
  always_comb begin
    if (table_size_r == '0) begin
      size_use = CNT_W'(1);
    end else if (CNT_W'(table_size_r) > CNT_W'(TABLE_DEPTH)) begin
      size_use = CNT_W'(TABLE_DEPTH);
    end else begin
      size_use = CNT_W'(table_size_r);
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r  <= in_payload.key_in;
      slot_r <= in_payload.slot_in;
    end
  end

  // Hash pipeline, one product per step
  assign mul_full  = (2*FRAC_W)'(key_r[FRAC_W-1:0]) * (2*FRAC_W)'(hash_mult_r);
  assign pct_full  = PCT_MUL_W'(mul_r) * PCT_MUL_W'(HUNDRED);
  assign scl_full  = SCL_W'(pct_r) * SCL_W'(size_use);
  assign home_full = HOME_MUL_W'(scl_r) * HOME_MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.hash_mul) begin
      mul_r <= mul_full[FRAC_W-1:0];
    end
    if (ctl.hash_pct) begin
      pct_r <= pct_full[FRAC_W +: PCT_W];
    end
    if (ctl.hash_scale) begin
      scl_r <= scl_full;
    end
  end

  // Probe address: start at home, advance with wrap at the size in use
  assign pos_inc = CNT_W'(iss_pos_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.hash_home) begin
      iss_pos_r <= home_full[RECIP_SHIFT +: ADDR_W];
      iss_cnt_r <= '0;
    end else if (ctl.probe_issue) begin
      iss_pos_r <= (pos_inc >= size_use) ? '0 : pos_inc[ADDR_W-1:0];
      iss_cnt_r <= iss_cnt_r + CNT_W'(1);
    end
  end

  // Read address and tracking of the word in flight
  assign issue = ctl.probe_issue | ctl.read_issue;
  assign raddr = ctl.read_issue ? slot_r[ADDR_W-1:0] : iss_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r  <= raddr;
    rd_last_r <= (iss_cnt_r == size_use - CNT_W'(1));
    rd_bit_r  <= valid_r[raddr];
  end

  // Per-slot valid bits stand in for the cleared store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[rd_pos_r] <= 1'b1;
    end
  end

  mhlp_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ctl.wr_en),
    .waddr(rd_pos_r),
    .wdata(key_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Compare the returned slot against the key
  assign held = rd_bit_r ? rdata : '0;

  always_comb begin
    sts.in_read     = (in_payload.cmd == CMD_READ);
    sts.in_zero_key = (in_payload.key_in == '0);
    sts.iss_more    = (iss_cnt_r < size_use);
    sts.hit_empty   = rd_vld_r && (held == '0);
    sts.hit_dup     = rd_vld_r && (held != '0) && (held == key_r);
    sts.hit_full    = rd_vld_r && (held != '0) && (held != key_r) && rd_last_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_payload_r.status <= ctl.res_status;
      case (ctl.res_sel)
        RES_SLOT_HELD: begin
          out_payload_r.slot_out <= SLOT_W'(rd_pos_r);
          out_payload_r.key_out  <= held;
        end
        RES_SLOT_KEY: begin
          out_payload_r.slot_out <= SLOT_W'(rd_pos_r);
          out_payload_r.key_out  <= key_r;
        end
        default: begin
          out_payload_r.slot_out <= '0;
          out_payload_r.key_out  <= '0;
        end
      endcase
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_payload_r;

endmodule
`default_nettype wire

[hw/rtl/mhlp_ctrl.sv]
// Controller: state machine that sequences hashing, probing, reads and results.
`timescale 1ns / 1ps
`default_nettype none
module mhlp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire mhlp_pkg::sts_t sts,
  output logic                busy,
  output mhlp_pkg::ctl_t      ctl
);
  import mhlp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   stop;

  assign stop = sts.hit_empty | sts.hit_dup | sts.hit_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.in_read) begin
            state_nxt = ST_READ_ISSUE;
          end else if (!sts.in_zero_key) begin
            state_nxt = ST_HASH_MUL;
          end
        end
      end
      ST_HASH_MUL:   state_nxt = ST_HASH_PCT;
      ST_HASH_PCT:   state_nxt = ST_HASH_SCALE;
      ST_HASH_SCALE: state_nxt = ST_HASH_HOME;
      ST_HASH_HOME:  state_nxt = ST_PROBE;
      ST_PROBE: begin
        if (stop) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ_ISSUE: state_nxt = ST_READ_WAIT;
      ST_READ_WAIT:  state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl            = '0;
    ctl.res_sel    = RES_ZERO;
    ctl.res_status = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        ctl.load = start;
        // Zero key answers at once and leaves the table alone
        if (start && !sts.in_read && sts.in_zero_key) begin
          ctl.emit       = 1'b1;
          ctl.res_sel    = RES_ZERO;
          ctl.res_status = STAT_ZERO;
        end
      end
      ST_HASH_MUL:   ctl.hash_mul   = 1'b1;
      ST_HASH_PCT:   ctl.hash_pct   = 1'b1;
      ST_HASH_SCALE: ctl.hash_scale = 1'b1;
      ST_HASH_HOME:  ctl.hash_home  = 1'b1;
      ST_PROBE: begin
        ctl.probe_issue = sts.iss_more && !stop;
        if (sts.hit_empty) begin
          ctl.wr_en      = 1'b1;
          ctl.emit       = 1'b1;
          ctl.res_sel    = RES_SLOT_KEY;
          ctl.res_status = STAT_OK;
        end else if (sts.hit_dup) begin
          ctl.emit       = 1'b1;
          ctl.res_sel    = RES_SLOT_HELD;
          ctl.res_status = STAT_DUP;
        end else if (sts.hit_full) begin
          ctl.emit       = 1'b1;
          ctl.res_sel    = RES_ZERO;
          ctl.res_status = STAT_FULL;
        end
      end
      ST_READ_ISSUE: ctl.read_issue = 1'b1;
      ST_READ_WAIT: begin
        ctl.emit       = 1'b1;
        ctl.res_sel    = RES_SLOT_HELD;
        ctl.res_status = STAT_OK;
      end
      default: ctl.load = 1'b0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

[hw/rtl/mult_hash_linear_probe_table_core.sv]
// Top level: multiplicative-hash table with linear probing, controller plus datapath.
//
//   channel   ports                                    handshake
//   --------  ---------------------------------------  ------------------------------
//   input     start, busy, in_payload                  taken when start and not busy
//   result    out_strobe, out_payload                  one cycle per item, no stall
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  taken when valid and ready
//
// An insert hashes in five steps (capture, three registered products, home
// slot), then probes: the slot store returns one word a cycle and the compare
// uses the registered word. A read issues its slot, then emits the word; a
// zero key answers at once. The result appears the cycle after the item ends.
// Reset is synchronous, active low, and empties the table at once through
// per-slot valid bits. The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module mult_hash_linear_probe_table_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire mhlp_pkg::in_item_t               in_payload,
  output logic                                  out_strobe,
  output mhlp_pkg::out_item_t                   out_payload,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mhlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mhlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mhlp_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  mhlp_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .ctl  (ctl)
  );

  mhlp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_payload (in_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_payload(out_payload)
  );

endmodule
`default_nettype wire

[sim/mult_hash_linear_probe_table_core_tb.sv]
// Testbench: hash table core checked against a shadow table, directed rows then random phases.
`timescale 1ns / 1ps
module mult_hash_linear_probe_table_core_tb;
  import mhlp_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 150;
  localparam int RANDOM_ITEMS    = 1550;
  localparam int PHASES          = 12;
  localparam int MAX_GAP         = 12;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    bit                    fixed;
    out_item_t             want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  in_item_t              in_payload = '0;
  logic                  out_strobe;
  out_item_t             out_payload;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Shadow copy of the table and its registers
  logic [KEY_BITS-1:0] shadow_keys [TABLE_DEPTH];
  logic [SIZE_W-1:0]   shadow_size;
  logic [MULT_W-1:0]   shadow_mult;

  out_item_t           pending_outcomes [$];
  logic [KEY_BITS-1:0] sent_keys [$];
  int                  fail_count  = 0;
  int                  idle_cycles = 0;
  int                  n_stored = 0, n_dup = 0, n_full = 0, n_zero = 0, n_reads = 0;

  mult_hash_linear_probe_table_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_strobe  (out_strobe),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Clamp the size register to the slots that exist
  function automatic int unsigned eff_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(shadow_size);
  endfunction

  // Outcome of one item on the shadow table; stores the key on a successful insert
  function automatic out_item_t table_outcome(in_item_t item);
    out_item_t   r;
    logic [63:0] prod;
    logic [63:0] pct;
    int unsigned size;
    int unsigned pos;
    int unsigned n;
    r.slot_out = '0;
    r.key_out  = '0;
    r.status   = STAT_OK;
    if (item.cmd == CMD_READ) begin
      r.slot_out = item.slot_in;
      r.key_out  = shadow_keys[item.slot_in];
      return r;
    end
    if (item.key_in == '0) begin
      r.status = STAT_ZERO;
      return r;
    end
    size = eff_size();
    prod = 64'(item.key_in) * 64'(shadow_mult);
    pct  = (64'(prod[FRAC_W-1:0]) * 64'(HUNDRED)) >> FRAC_W;
    pos  = int'((pct * 64'(size)) / 64'(HUNDRED));
    for (n = 0; n < size; n++) begin
      if (shadow_keys[pos] == '0) begin
        shadow_keys[pos] = item.key_in;
        r.slot_out = 7'(pos);
        r.key_out  = item.key_in;
        return r;
      end
      if (shadow_keys[pos] == item.key_in) begin
        r.slot_out = 7'(pos);
        r.key_out  = item.key_in;
        r.status   = STAT_DUP;
        return r;
      end
      pos++;
      if (pos >= size) pos = 0;
    end
    r.status = STAT_FULL;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.item   = '0;
    r.fixed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t item_row(cmd_t cmd, logic [KEY_BITS-1:0] key,
                                         logic [SLOT_W-1:0] slot);
    stim_row_t r;
    r.is_cfg       = 1'b0;
    r.idx          = '0;
    r.data         = '0;
    r.item.cmd     = cmd;
    r.item.key_in  = key;
    r.item.slot_in = slot;
    r.fixed        = 1'b0;
    r.want         = '0;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(cmd_t cmd, logic [KEY_BITS-1:0] key,
                                          logic [SLOT_W-1:0] slot, logic [SLOT_W-1:0] slot_o,
                                          logic [KEY_BITS-1:0] key_o, status_t st);
    stim_row_t r;
    r = item_row(cmd, key, slot);
    r.fixed         = 1'b1;
    r.want.slot_out = slot_o;
    r.want.key_out  = key_o;
    r.want.status   = st;
    return r;
  endfunction

  // Present one item after a gap, hold start until taken, then queue its outcome
  task automatic send_item(input in_item_t item, input bit fixed, input out_item_t fixed_want,
                           input int gap);
    out_item_t want;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start      = 1'b1;
    in_payload = item;
    do @(posedge clk); while (busy !== 1'b0);
    want = table_outcome(item);
    if (fixed) want = fixed_want;
    pending_outcomes.push_back(want);
    if (item.cmd == CMD_READ) n_reads++;
    else begin
      if (item.key_in != '0) sent_keys.push_back(item.key_in);
      case (want.status)
        STAT_OK:   n_stored++;
        STAT_DUP:  n_dup++;
        STAT_FULL: n_full++;
        default:   n_zero++;
      endcase
    end
  endtask

  // Drop start and wait until every queued outcome has come back
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_TABLE_SIZE) shadow_size = data[SIZE_W-1:0];
    else if (idx == CFG_HASH_MULT) shadow_mult = data[MULT_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Compare each result with the oldest queued outcome
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing queued: slot %0d key %0h status %0d",
               out_payload.slot_out, out_payload.key_out, out_payload.status);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_payload.slot_out !== want.slot_out) begin
          $error("slot_out expected %0d actual %0d", want.slot_out, out_payload.slot_out);
          fail_count++;
        end
        if (out_payload.key_out !== want.key_out) begin
          $error("key_out expected %0h actual %0h", want.key_out, out_payload.key_out);
          fail_count++;
        end
        if (out_payload.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_payload.status);
          fail_count++;
        end
      end
    end
  end

  // End the run when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("[mult_hash_linear_probe_table_core] ERROR");
      $finish;
    end
  end

  initial begin : main
    stim_row_t           dir_rows [$];
    logic [SIZE_W-1:0]   phase_size [PHASES];
    logic [MULT_W-1:0]   mult;
    in_item_t            item;
    bit                  burst;
    int unsigned         pick;
    int                  ph;
    int                  n;

    phase_size = '{8'd1, 8'd0, 8'd3, 8'd8, 8'd16, 8'd33, 8'd64, 8'd100,
                   8'd127, 8'd128, 8'd255, 8'd2};
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    shadow_size = SIZE_RESET;
    shadow_mult = MULT_RESET;

    // Directed rows: empty table, extremes, full table, size clamping, stale keys
    dir_rows.push_back(fixed_row(CMD_READ, 20'h0, 7'd0, 7'd0, 20'h0, STAT_OK));
    dir_rows.push_back(fixed_row(CMD_READ, 20'hFFFFF, 7'd127, 7'd127, 20'h0, STAT_OK));
    dir_rows.push_back(fixed_row(CMD_INSERT, 20'h0, 7'd127, 7'd0, 20'h0, STAT_ZERO));
    dir_rows.push_back(item_row(CMD_INSERT, 20'hFFFFF, 7'd0));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h00001, 7'd0));
    dir_rows.push_back(item_row(CMD_INSERT, 20'hFFFFF, 7'd127));
    dir_rows.push_back(item_row(CMD_INSERT, 20'hAAAAA, 7'd85));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h55555, 7'd42));
    dir_rows.push_back(item_row(CMD_READ, 20'h0, 7'd64));
    dir_rows.push_back(cfg_row(CFG_TABLE_SIZE, 16'h0001));
    dir_rows.push_back(cfg_row(CFG_HASH_MULT, 16'hFFFF));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h12345, 7'd0));
    // One slot in use and a fresh key: must be full
    dir_rows.push_back(fixed_row(CMD_INSERT, 20'h54321, 7'd0, 7'd0, 20'h0, STAT_FULL));
    // Size zero acts as one slot
    dir_rows.push_back(cfg_row(CFG_TABLE_SIZE, 16'hFF00));
    dir_rows.push_back(fixed_row(CMD_INSERT, 20'h0F0F0, 7'd0, 7'd0, 20'h0, STAT_FULL));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h12345, 7'd0));
    // Size above depth clamps; unknown indexes are ignored
    dir_rows.push_back(cfg_row(CFG_TABLE_SIZE, 16'h00FF));
    dir_rows.push_back(cfg_row(CFG_HASH_MULT, 16'h0001));
    dir_rows.push_back(cfg_row(CFG_IDX_W'(2), 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_IDX_W'(15), 16'h0000));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h00001, 7'd0));
    dir_rows.push_back(item_row(CMD_INSERT, 20'hFFFFF, 7'd0));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h00002, 7'd0));
    // Shrink below stored keys: a key above the size may be stored again
    dir_rows.push_back(cfg_row(CFG_TABLE_SIZE, 16'h0002));
    dir_rows.push_back(item_row(CMD_INSERT, 20'hFFFFF, 7'd0));
    dir_rows.push_back(item_row(CMD_READ, 20'h0, 7'd127));
    dir_rows.push_back(item_row(CMD_READ, 20'h0, 7'd2));
    dir_rows.push_back(cfg_row(CFG_TABLE_SIZE, 16'h0080));
    dir_rows.push_back(cfg_row(CFG_HASH_MULT, MULT_RESET));
    dir_rows.push_back(item_row(CMD_INSERT, 20'h80000, 7'd0));
    dir_rows.push_back(item_row(CMD_READ, 20'h0, 7'd1));

    // Hold reset, then release it at a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cfg(dir_rows[i].idx, dir_rows[i].data);
      else send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want,
                     $urandom_range(0, MAX_GAP));
    end

    // Random phases: table size mostly grows so the table fills gradually, then shrinks at the end
    burst = 1'b0;
    for (ph = 0; ph < PHASES; ph++) begin
      write_cfg(CFG_TABLE_SIZE, {8'($urandom), phase_size[ph]});
      case (ph)
        0:       mult = 16'h0001;
        1:       mult = 16'hFFFF;
        2:       mult = 16'h0000;
        3:       mult = MULT_RESET;
        default: mult = 16'($urandom_range(1, 65535));
      endcase
      write_cfg(CFG_HASH_MULT, mult);
      if (ph == 5) write_cfg(CFG_IDX_W'($urandom_range(2, 15)), 16'($urandom));
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
        item.slot_in = 7'($urandom);
        item.key_in  = 20'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          item.cmd = CMD_READ;
          if ($urandom_range(0, 1) == 1) item.slot_in = 7'($urandom_range(0, eff_size() - 1));
        end else begin
          item.cmd = CMD_INSERT;
          if (pick < 25) item.key_in = '0;
          else if (pick < 50 && sent_keys.size() != 0)
            item.key_in = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
          else if (pick < 62) item.key_in = 20'($urandom_range(1, 255));
          else item.key_in = 20'($urandom_range(1, 20'hFFFFF));
        end
        send_item(item, 1'b0, '0, burst ? 0 : $urandom_range(0, MAX_GAP));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("inserts: %0d stored, %0d duplicate, %0d full, %0d zero key; %0d slot reads",
             n_stored, n_dup, n_full, n_zero, n_reads);
    $display("random part ran %0d table size and multiplier settings, %0d mismatches",
             PHASES, fail_count);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("[mult_hash_linear_probe_table_core] OK");
    end else begin
      $display("[mult_hash_linear_probe_table_core] ERROR");
    end
    $finish;
  end

endmodule
